FILE: design/drdr_pkg.sv
// ----------------------------------------------------------------------------
// drdr_pkg: shared types and constants of the dirty-run refresh core
// Holds the panel command codes, register indexes, reset values, the queue
// entry passed from the front end to the back end and the header sequencer.
// ----------------------------------------------------------------------------
package drdr_pkg;

   // Panel command codes.
   localparam logic [15:0] CMD_COLUMN_ADDR = 16'h002A;
   localparam logic [15:0] CMD_PAGE_ADDR   = 16'h002B;
   localparam logic [15:0] CMD_MEM_WRITE   = 16'h002C;

   // Configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 10;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISPLAY_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RUN_EXTENSION = 2'd1;

   localparam logic [9:0] DISPLAY_WIDTH_RESET = 10'd480;
   localparam logic [8:0] RUN_EXTENSION_RESET = 9'd40;

   // Largest column that a 9-bit window address can name.
   localparam logic [8:0] COLUMN_LIMIT = 9'h1FF;

   // Queue between front end and back end.
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_PTR_WIDTH = 2;

   typedef struct packed {
      logic       is_header;   // 1: open a run with a window header
      logic [8:0] row;
      logic [8:0] column;
      logic [8:0] end_column;
      logic [15:0] pixel;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Bus writes of a run header, in order.
   typedef enum logic [3:0] {
      STEP_COLUMN_CMD,
      STEP_START_HIGH,
      STEP_START_LOW,
      STEP_END_HIGH,
      STEP_END_LOW,
      STEP_PAGE_CMD,
      STEP_ROW_HIGH,
      STEP_ROW_LOW,
      STEP_ROW_END_HIGH,
      STEP_ROW_END_LOW,
      STEP_WRITE_CMD,
      STEP_PIXEL
   } header_step_type;

endpackage

FILE: design/drdr_ram.sv
// ----------------------------------------------------------------------------
// drdr_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module drdr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

FILE: design/drdr_front.sv
// ----------------------------------------------------------------------------
// drdr_front: pixel intake, shadow compare and run tracking
// Reads the shadow copy of each pixel, decides whether the pixel opens a
// run, continues one or is dropped, updates the shadow and pushes the work
// for the bus sequencer into the queue. Clears the shadow after reset.
// ----------------------------------------------------------------------------
module drdr_front #(
   parameter int unsigned MAX_COLUMNS = 512,
   parameter int unsigned MAX_ROWS    = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [8:0]                req_row,
   input  logic [8:0]                req_column,
   input  logic [15:0]               req_pixel,
   input  logic [9:0]                display_width,
   input  logic [8:0]                run_extension,
   output logic                      queue_push,
   output drdr_pkg::queue_entry_type queue_entry,
   input  drdr_pkg::queue_status_type queue_status
);

   localparam int unsigned DEPTH      = MAX_ROWS * MAX_COLUMNS;
   localparam int unsigned ADDR_WIDTH = $clog2(DEPTH);

   // Clearing pass.
   logic                  clear_busy_ff, clear_busy_in;
   logic [ADDR_WIDTH-1:0] clear_addr_ff, clear_addr_in;

   // Compare stage.
   logic                  b_valid_ff, b_valid_in;
   logic                  b_in_range_ff;
   logic [8:0]            b_row_ff;
   logic [8:0]            b_column_ff;
   logic [15:0]           b_pixel_ff;
   logic [ADDR_WIDTH-1:0] b_addr_ff;

   // Last shadow write, forwarded to the item that read under it.
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [ADDR_WIDTH-1:0] fwd_addr_ff;
   logic [15:0]           fwd_data_ff;

   // Open run.
   logic       run_open_ff, run_open_in;
   logic [8:0] run_last_ff, run_last_in;
   logic [8:0] run_row_ff, run_row_in;

   logic                  accept;
   logic                  a_in_range;
   logic [ADDR_WIDTH-1:0] a_addr;
   logic [15:0]           ram_read_data;
   logic [15:0]           shadow_value;
   logic                  in_run;
   logic                  changed;
   logic                  need_push;
   logic                  b_advance;
   logic                  b_act;
   logic                  shadow_write;
   logic [9:0]            limit_wide;
   logic [8:0]            limit;
   logic [9:0]            end_wide;
   logic [8:0]            end_column;
   logic                  ram_write_enable;
   logic [ADDR_WIDTH-1:0] ram_write_addr;
   logic [15:0]           ram_write_data;

   // Intake.
   assign a_in_range = ({1'b0, req_column} < display_width)
                       && (32'(req_row) < MAX_ROWS)
                       && (32'(req_column) < MAX_COLUMNS);
   assign a_addr     = ADDR_WIDTH'(32'(req_row) * MAX_COLUMNS + 32'(req_column));
   assign req_stall  = clear_busy_ff || (b_valid_ff && !b_advance);
   assign accept     = req_valid && !req_stall;

   // Classification.
   assign shadow_value = (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff
                                                                      : ram_read_data;
   assign in_run     = run_open_ff && (b_row_ff == run_row_ff) && (b_column_ff <= run_last_ff);
   assign changed    = shadow_value != b_pixel_ff;
   assign need_push  = b_in_range_ff && (in_run || changed);
   assign b_advance  = b_valid_ff && (!need_push || !queue_status.full);
   assign b_act      = b_advance && b_in_range_ff;
   assign shadow_write = b_act && (in_run || changed);

   // Run end, held below the visible width and the column range.
   always_comb begin
      limit_wide = display_width - 10'd1;
      limit      = (limit_wide > {1'b0, drdr_pkg::COLUMN_LIMIT}) ? drdr_pkg::COLUMN_LIMIT
                                                                 : limit_wide[8:0];
      end_wide   = {1'b0, b_column_ff} + {1'b0, run_extension};
      end_column = (end_wide > {1'b0, limit}) ? limit : end_wide[8:0];
   end

   assign queue_push             = b_act && need_push;
   assign queue_entry.is_header  = !in_run;
   assign queue_entry.row        = b_row_ff;
   assign queue_entry.column     = b_column_ff;
   assign queue_entry.end_column = end_column;
   assign queue_entry.pixel      = b_pixel_ff;

   always_comb begin
      run_open_in = run_open_ff;
      run_last_in = run_last_ff;
      run_row_in  = run_row_ff;
      if (b_act) begin
         if (in_run) begin
            if (b_column_ff == run_last_ff) begin
               run_open_in = 1'b0;
            end
         end else begin
            run_open_in = 1'b0;
            if (changed && (end_column > b_column_ff)) begin
               run_open_in = 1'b1;
               run_last_in = end_column;
               run_row_in  = b_row_ff;
            end
         end
      end
   end

   always_comb begin
      b_valid_in    = accept || (b_valid_ff && !b_advance);
      fwd_valid_in  = fwd_valid_ff || shadow_write;
      clear_busy_in = clear_busy_ff && (clear_addr_ff != ADDR_WIDTH'(DEPTH - 1));
      clear_addr_in = clear_busy_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         b_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         run_open_ff   <= 1'b0;
         run_last_ff   <= '0;
         run_row_ff    <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         b_valid_ff    <= b_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         run_open_ff   <= run_open_in;
         run_last_ff   <= run_last_in;
         run_row_ff    <= run_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_in_range_ff <= a_in_range;
         b_row_ff      <= req_row;
         b_column_ff   <= req_column;
         b_pixel_ff    <= req_pixel;
         b_addr_ff     <= a_addr;
      end
      if (shadow_write) begin
         fwd_addr_ff <= b_addr_ff;
         fwd_data_ff <= b_pixel_ff;
      end
   end

   // The clearing pass owns the write port until it finishes.
   assign ram_write_enable = clear_busy_ff || shadow_write;
   assign ram_write_addr   = clear_busy_ff ? clear_addr_ff : b_addr_ff;
   assign ram_write_data   = clear_busy_ff ? 16'h0000 : b_pixel_ff;

   drdr_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_shadow (
      .clock        (clock),
      .write_enable (ram_write_enable),
      .write_addr   (ram_write_addr),
      .write_data   (ram_write_data),
      .read_enable  (accept && a_in_range),
      .read_addr    (a_addr),
      .read_data    (ram_read_data)
   );

endmodule

FILE: design/drdr_queue.sv
// ----------------------------------------------------------------------------
// drdr_queue: short work queue between front end and bus sequencer
// Small flip-flop FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module drdr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  drdr_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output drdr_pkg::queue_entry_type  head_entry,
   output drdr_pkg::queue_status_type status
);

   localparam int unsigned PW = drdr_pkg::QUEUE_PTR_WIDTH;

   drdr_pkg::queue_entry_type entry_ff [drdr_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign status.full  = count_ff == (PW+1)'(drdr_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/drdr_back.sv
// ----------------------------------------------------------------------------
// drdr_back: bus write sequencer
// Turns each queue entry into panel bus writes: twelve for a run header,
// one for a pixel inside a run, through a registered output stage.
// ----------------------------------------------------------------------------
module drdr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  drdr_pkg::queue_entry_type  head_entry,
   input  drdr_pkg::queue_status_type queue_status,
   output logic                       queue_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_is_command,
   output logic [15:0]                rsp_bus_value,
   output logic                       rsp_last
);

   drdr_pkg::header_step_type step_ff, step_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_is_command_ff;
   logic [15:0] rsp_bus_value_ff;
   logic        rsp_last_ff;

   logic        head_valid;
   logic        load;
   logic        word_is_command;
   logic [15:0] word_value;
   logic        word_last;

   assign head_valid = !queue_status.empty;
   assign load       = !rsp_valid_ff || !rsp_stall;
   assign queue_pop  = load && head_valid && word_last;

   // Next step of the header sequence.
   always_comb begin
      step_in = step_ff;
      if (load && head_valid && head_entry.is_header) begin
         if (step_ff == drdr_pkg::STEP_PIXEL) begin
            step_in = drdr_pkg::STEP_COLUMN_CMD;
         end else begin
            step_in = drdr_pkg::header_step_type'(4'(step_ff + 4'd1));
         end
      end
   end

   // Bus word for the current step.
   always_comb begin
      word_is_command = 1'b0;
      word_value      = head_entry.pixel;
      word_last       = 1'b1;
      if (head_entry.is_header) begin
         word_last = 1'b0;
         unique case (step_ff)
            drdr_pkg::STEP_COLUMN_CMD: begin
               word_is_command = 1'b1;
               word_value      = drdr_pkg::CMD_COLUMN_ADDR;
            end
            drdr_pkg::STEP_START_HIGH:   word_value = {15'd0, head_entry.column[8]};
            drdr_pkg::STEP_START_LOW:    word_value = {8'd0, head_entry.column[7:0]};
            drdr_pkg::STEP_END_HIGH:     word_value = {15'd0, head_entry.end_column[8]};
            drdr_pkg::STEP_END_LOW:      word_value = {8'd0, head_entry.end_column[7:0]};
            drdr_pkg::STEP_PAGE_CMD: begin
               word_is_command = 1'b1;
               word_value      = drdr_pkg::CMD_PAGE_ADDR;
            end
            drdr_pkg::STEP_ROW_HIGH,
            drdr_pkg::STEP_ROW_END_HIGH: word_value = {15'd0, head_entry.row[8]};
            drdr_pkg::STEP_ROW_LOW,
            drdr_pkg::STEP_ROW_END_LOW:  word_value = {8'd0, head_entry.row[7:0]};
            drdr_pkg::STEP_WRITE_CMD: begin
               word_is_command = 1'b1;
               word_value      = drdr_pkg::CMD_MEM_WRITE;
            end
            drdr_pkg::STEP_PIXEL: begin
               word_value = head_entry.pixel;
               word_last  = 1'b1;
            end
            default: begin
               word_value = head_entry.pixel;
               word_last  = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid_in = load ? head_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= drdr_pkg::STEP_COLUMN_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         rsp_is_command_ff <= word_is_command;
         rsp_bus_value_ff  <= word_value;
         rsp_last_ff       <= word_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_command = rsp_is_command_ff;
   assign rsp_bus_value  = rsp_bus_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

FILE: design/dirty_run_display_refresh_core.sv
// ----------------------------------------------------------------------------
// dirty_run_display_refresh_core: partial panel refresh from a pixel stream
// Sends to the panel bus only the runs of pixels that differ from a shadow
// copy of what the panel already shows.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one pixel per transfer (row, column, RGB565 color)
// in raster order. The rsp_ channel gives panel bus writes, one per
// transfer: rsp_is_command picks the command or the data port, and rsp_last
// marks a pixel's final write. A changed in-range pixel outside an open
// run gives twelve writes (column window, page window, memory write command,
// then the pixel); a pixel inside an open run gives one; other pixels none.
// The csr_ port sets display_width (index 0) and run_extension (index 1);
// write it only while the block is idle.
// A req_ transfer passes the compare stage, work queue and output register.
// The block takes one pixel per cycle unless req_stall is high; rsp_ gives
// one write per cycle unless rsp_stall is high; a run header takes twelve
// writes, and the four-entry work queue then fills and holds req_ off.
// After reset a clearing pass zeroes the shadow memory, one entry per cycle,
// all MAX_ROWS * MAX_COLUMNS entries; req_stall stays high until it is done.
// When rsp_stall is high the output register holds its write, the queue
// fills, and req_stall rises once the compare stage cannot drain.
// ----------------------------------------------------------------------------
module dirty_run_display_refresh_core #(
   parameter int unsigned MAX_COLUMNS = 512,
   parameter int unsigned MAX_ROWS    = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Pixel input.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_row,
   input  logic [8:0]  req_column,
   input  logic [15:0] req_pixel,
   // Panel bus writes.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_command,
   output logic [15:0] rsp_bus_value,
   output logic        rsp_last,
   // Configuration writes.
   input  logic                                  csr_write_enable,
   input  logic [drdr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [drdr_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   logic [9:0] display_width_ff, display_width_in;
   logic [8:0] run_extension_ff, run_extension_in;

   logic                       queue_push;
   logic                       queue_pop;
   drdr_pkg::queue_entry_type  push_entry;
   drdr_pkg::queue_entry_type  head_entry;
   drdr_pkg::queue_status_type queue_status;

   // Register decode. Indexes beyond the list are ignored.
   always_comb begin
      display_width_in = display_width_ff;
      run_extension_in = run_extension_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            drdr_pkg::CSR_DISPLAY_WIDTH: display_width_in = csr_write_data;
            drdr_pkg::CSR_RUN_EXTENSION: run_extension_in = csr_write_data[8:0];
            default: begin
               display_width_in = display_width_ff;
               run_extension_in = run_extension_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_width_ff <= drdr_pkg::DISPLAY_WIDTH_RESET;
         run_extension_ff <= drdr_pkg::RUN_EXTENSION_RESET;
      end else begin
         display_width_ff <= display_width_in;
         run_extension_ff <= run_extension_in;
      end
   end

   // Front end: shadow compare and run tracking.
   drdr_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_row       (req_row),
      .req_column    (req_column),
      .req_pixel     (req_pixel),
      .display_width (display_width_ff),
      .run_extension (run_extension_ff),
      .queue_push    (queue_push),
      .queue_entry   (push_entry),
      .queue_status  (queue_status)
   );

   // Work queue lets the front end keep taking pixels while headers go out.
   drdr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   // Back end: bus write sequencer with output register.
   drdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .queue_status   (queue_status),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_command (rsp_is_command),
      .rsp_bus_value  (rsp_bus_value),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // The clearing pass must hold input off right after reset.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("pixel input open during shadow clearing pass");

   // The front end never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset) !(queue_push && queue_status.full))
      else $error("work queue overflow");

   // The sequencer never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) queue_pop |-> !queue_status.empty)
      else $error("work queue underflow");

   // A pixel's final bus write always goes to the data port.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_last) |-> !rsp_is_command)
      else $error("command write marked as last");
`endif

endmodule
